// File: rtl/core/mars_pkg.sv
// mars_pkg: shared types, constants and saturating helpers for the
// multimode respectrum filter. no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package mars_pkg;

  localparam int MaxChannels = 256;
  localparam int ChanBits    = 8;
  localparam int SampleBits  = 24;
  localparam int QBits       = 32;

  localparam logic [QBits-1:0] QOne    = 32'h0080_0000;
  localparam logic [QBits-1:0] QNegOne = 32'hFF80_0000;
  localparam logic [QBits-1:0] QMax    = 32'h7FFF_FFFF;
  localparam logic [QBits-1:0] QMin    = 32'h8000_0000;

  localparam logic [1:0] RegMode    = 2'd0;
  localparam logic [1:0] RegReverse = 2'd1;
  localparam logic [1:0] RegCount   = 2'd2;

  typedef enum logic [3:0] {
    MODE_COPY     = 4'd0,
    MODE_DIFF_RS  = 4'd1,
    MODE_COMPLETE = 4'd2,
    MODE_RS       = 4'd3,
    MODE_SQUARE   = 4'd4,
    MODE_SQRT     = 4'd5,
    MODE_AVERAGE  = 4'd6,
    MODE_DIFF     = 4'd7,
    MODE_INTEGRAL = 4'd8
  } mode_t;

  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE, ST_READ, ST_LOAD, ST_PRE, ST_SQ_MUL, ST_SQ_DONE,
    ST_CAS1A, ST_CAS1B, ST_CAS1C, ST_CAS2A, ST_CAS2B, ST_CAS2C,
    ST_ROOT_GO, ST_ROOT_WAIT, ST_POST, ST_REV, ST_OUT, ST_HOLD
  } state_t;

  // request to the root unit and its reply
  typedef struct packed {
    logic             start;
    logic [QBits-1:0] radicand;
  } root_req_t;

  typedef struct packed {
    logic             done;
    logic [QBits-1:0] root;
  } root_rsp_t;

  function automatic logic [QBits-1:0] sat33(input logic [QBits:0] v);
    logic [QBits-1:0] r;
    r = v[QBits-1:0];
    if (v[QBits] != v[QBits-1]) r = v[QBits] ? QMin : QMax;
    return r;
  endfunction

  function automatic logic [QBits-1:0] sat_add(input logic [QBits-1:0] a,
                                              input logic [QBits-1:0] b);
    return sat33({a[QBits-1], a} + {b[QBits-1], b});
  endfunction

  function automatic logic [QBits-1:0] sat_sub(input logic [QBits-1:0] a,
                                              input logic [QBits-1:0] b);
    return sat33({a[QBits-1], a} - {b[QBits-1], b});
  endfunction

  // floor((a+b)/2), never overflows
  function automatic logic [QBits-1:0] half_sum(input logic [QBits-1:0] a,
                                               input logic [QBits-1:0] b);
    logic [QBits:0] s;
    s = {a[QBits-1], a} + {b[QBits-1], b};
    return s[QBits:1];
  endfunction

  // magnitude, most negative saturates
  function automatic logic [QBits-1:0] abs_sat(input logic [QBits-1:0] a);
    logic [QBits-1:0] r;
    r = a[QBits-1] ? (~a + 32'd1) : a;
    if (a == QMin) r = QMax;
    return r;
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/multimode_audio_respectrum_filter.sv
// multimode_audio_respectrum_filter: sequencer, channel memories and output stage.
// depends on mars_pkg and mars_root.
// one item at a time: the next input is taken in the cycle after the result is loaded;
// the 16-step square and the 27-step bit-serial root set the rate.
// reset (rst, synchronous) runs a pass clearing the channel memories; no input is taken
// during it. configuration writes are taken at any time outside reset.
`timescale 1ns / 1ps
`default_nettype none
module multimode_audio_respectrum_filter (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [23:0] sample_in,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [23:0]      sample_out,
  output logic [7:0]       channel_index
);

  localparam int QB = mars_pkg::QBits;
  localparam int CB = mars_pkg::ChanBits;

  logic [3:0] mode;
  logic       reverse;
  logic [8:0] channel_count;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= 4'(mars_pkg::MODE_COPY);
      reverse       <= 1'b0;
      channel_count <= 9'd1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        mars_pkg::RegMode:    mode          <= cfg_data[3:0];
        mars_pkg::RegReverse: reverse       <= cfg_data[0];
        mars_pkg::RegCount:   channel_count <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  mars_pkg::state_t state, state_next;
  logic [CB-1:0] chan;
  logic [CB:0]   clr_cnt;
  logic [QB-1:0] x, v, a, p, mb, mc, me, mf, cas;
  logic [4:0]    bit_cnt;
  logic [63:0]   prod;
  logic [QB-1:0] mag;
  logic          second;
  logic [23:0]   out_sample;
  logic [CB-1:0] out_chan;
  logic          out_full;

  // channel memories
  logic [QB-1:0] mem_b [mars_pkg::MaxChannels];
  logic [QB-1:0] mem_c [mars_pkg::MaxChannels];
  logic [QB-1:0] mem_e [mars_pkg::MaxChannels];
  logic [QB-1:0] mem_f [mars_pkg::MaxChannels];
  logic [QB-1:0] rd_b, rd_c, rd_e, rd_f;
  logic          we_b, we_c, we_e, we_f;
  logic [QB-1:0] wd_b, wd_c, wd_e, wd_f;
  logic [CB-1:0] waddr;

  always_ff @(posedge clk) begin
    if (we_b) mem_b[waddr] <= wd_b;
    if (we_c) mem_c[waddr] <= wd_c;
    if (we_e) mem_e[waddr] <= wd_e;
    if (we_f) mem_f[waddr] <= wd_f;
    rd_b <= mem_b[chan];
    rd_c <= mem_c[chan];
    rd_e <= mem_e[chan];
    rd_f <= mem_f[chan];
  end

  mars_pkg::root_req_t root_req;
  mars_pkg::root_rsp_t root_rsp;

  mars_root u_root (
    .clk (clk),
    .rst (rst),
    .req (root_req),
    .rsp (root_rsp)
  );

  assign in_stall      = (state != mars_pkg::ST_IDLE);
  assign out_valid     = out_full;
  assign sample_out    = out_sample;
  assign channel_index = out_chan;

  logic is_cas2;
  assign is_cas2 = second;

  always_comb begin
    state_next = state;
    unique case (state)
      mars_pkg::ST_CLEAR:     if (clr_cnt[CB]) state_next = mars_pkg::ST_IDLE;
      mars_pkg::ST_IDLE:      if (in_valid) state_next = mars_pkg::ST_READ;
      mars_pkg::ST_READ:      state_next = mars_pkg::ST_LOAD;
      mars_pkg::ST_LOAD:      state_next = mars_pkg::ST_PRE;
      mars_pkg::ST_PRE: begin
        priority case (mode)
          4'(mars_pkg::MODE_DIFF_RS), 4'(mars_pkg::MODE_COMPLETE),
          4'(mars_pkg::MODE_RS), 4'(mars_pkg::MODE_SQUARE):
            state_next = mars_pkg::ST_SQ_MUL;
          4'(mars_pkg::MODE_SQRT): state_next = mars_pkg::ST_ROOT_GO;
          default: state_next = mars_pkg::ST_REV;
        endcase
      end
      mars_pkg::ST_SQ_MUL:    if (bit_cnt == 5'd0) state_next = mars_pkg::ST_SQ_DONE;
      mars_pkg::ST_SQ_DONE:
        state_next = (mode == 4'(mars_pkg::MODE_SQUARE)) ? mars_pkg::ST_REV
                                                         : mars_pkg::ST_CAS1A;
      mars_pkg::ST_CAS1A:     state_next = mars_pkg::ST_CAS1B;
      mars_pkg::ST_CAS1B:     state_next = mars_pkg::ST_CAS1C;
      mars_pkg::ST_CAS1C:
        state_next = (mode == 4'(mars_pkg::MODE_COMPLETE) && !second)
                     ? mars_pkg::ST_CAS2A : mars_pkg::ST_ROOT_GO;
      mars_pkg::ST_CAS2A:     state_next = mars_pkg::ST_CAS1B;
      mars_pkg::ST_ROOT_GO:   state_next = mars_pkg::ST_ROOT_WAIT;
      mars_pkg::ST_ROOT_WAIT: if (root_rsp.done) state_next = mars_pkg::ST_POST;
      mars_pkg::ST_POST:      state_next = mars_pkg::ST_REV;
      mars_pkg::ST_REV:       state_next = mars_pkg::ST_OUT;
      mars_pkg::ST_OUT:       if (!out_full || !out_stall) state_next = mars_pkg::ST_IDLE;
      default:                state_next = mars_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    root_req.start    = (state == mars_pkg::ST_ROOT_GO);
    root_req.radicand = mars_pkg::abs_sat(a);
  end

  logic [QB-1:0] signed_root, folded, mirrored, clamped;
  always_comb begin
    logic neg;
    neg = (mode == 4'(mars_pkg::MODE_DIFF_RS)) ? v[QB-1] : x[QB-1];
    signed_root = neg ? (~root_rsp.root + 32'd1) : root_rsp.root;
    folded = signed_root;
    if ($signed(folded) > $signed(mars_pkg::QOne))
      folded = mars_pkg::sat_sub(mars_pkg::QOne, folded);
    if ($signed(folded) < $signed(mars_pkg::QNegOne))
      folded = mars_pkg::sat_sub(mars_pkg::QNegOne, folded);
    if (reverse) begin
      if (mode > 4'd1) mirrored = mars_pkg::sat_add(x, mars_pkg::sat_sub(x, v));
      else mirrored = mars_pkg::sat_sub(32'd0, v);
    end else begin
      mirrored = v;
    end
    clamped = mirrored;
    if ($signed(clamped) < $signed(mars_pkg::QNegOne)) clamped = mars_pkg::QNegOne;
    if ($signed(clamped) > $signed(mars_pkg::QOne)) clamped = mars_pkg::QOne;
  end

  logic [CB-1:0] chan_next;
  always_comb begin
    logic [8:0] cnt;
    cnt = (channel_count == 9'd0) ? 9'd1 : channel_count;
    if (cnt > 9'(mars_pkg::MaxChannels)) cnt = 9'(mars_pkg::MaxChannels);
    chan_next = ({1'b0, chan} + 9'd1 > cnt - 9'd1) ? '0 : chan + 8'd1;
  end

  // multiplier operands for the square
  logic [QB-1:0] diff_e, mag_d, mag_x;
  always_comb begin
    diff_e = mars_pkg::sat_sub(x, me);
    mag_d  = mars_pkg::abs_sat(diff_e);
    mag_x  = mars_pkg::abs_sat(x);
  end

  // one 32x2 partial product per cycle
  logic [33:0] pp, acc;
  always_comb begin
    pp  = (prod[0] ? {2'b00, mag} : 34'd0) + (prod[1] ? {1'b0, mag, 1'b0} : 34'd0);
    acc = {2'b00, prod[63:32]} + pp;
  end

  // square scaled back to q.23, saturated
  logic [QB-1:0] sq_val;
  assign sq_val = (|prod[63:54]) ? mars_pkg::QMax : {1'b0, prod[53:23]};

  always_ff @(posedge clk) begin
    we_b <= 1'b0; we_c <= 1'b0; we_e <= 1'b0; we_f <= 1'b0;
    if (rst) begin
      state    <= mars_pkg::ST_CLEAR;
      clr_cnt  <= '0;
      chan     <= '0;
      out_full <= 1'b0;
      we_b <= 1'b1; we_c <= 1'b1; we_e <= 1'b1; we_f <= 1'b1;
      waddr <= '0;
      wd_b <= '0; wd_c <= '0; wd_e <= '0; wd_f <= '0;
    end else begin
      state <= state_next;
      if (out_full && !out_stall) out_full <= 1'b0;
      unique case (state)
        mars_pkg::ST_CLEAR: begin
          clr_cnt <= clr_cnt + 9'd1;
          if (!clr_cnt[CB]) begin
            waddr <= clr_cnt[CB-1:0];
            wd_b <= '0; wd_c <= '0; wd_e <= '0; wd_f <= '0;
            we_b <= 1'b1; we_c <= 1'b1; we_e <= 1'b1; we_f <= 1'b1;
          end
        end
        mars_pkg::ST_IDLE: if (in_valid) begin
          x <= {{8{sample_in[23]}}, sample_in};
          v <= {{8{sample_in[23]}}, sample_in};
          second <= 1'b0;
        end
        mars_pkg::ST_READ: ;
        mars_pkg::ST_LOAD: begin
          mb <= rd_b; mc <= rd_c; me <= rd_e; mf <= rd_f;
        end
        mars_pkg::ST_PRE: begin
          waddr <= chan;
          unique case (mode)
            4'(mars_pkg::MODE_DIFF_RS): begin
              v <= diff_e;
              mag <= mag_d;
              prod <= {32'd0, mag_d};
              bit_cnt <= 5'd15;
              wd_e <= x; we_e <= 1'b1;
            end
            4'(mars_pkg::MODE_COMPLETE), 4'(mars_pkg::MODE_RS),
            4'(mars_pkg::MODE_SQUARE): begin
              mag <= mag_x;
              prod <= {32'd0, mag_x};
              bit_cnt <= 5'd15;
            end
            4'(mars_pkg::MODE_SQRT): a <= x;
            4'(mars_pkg::MODE_AVERAGE): begin
              v <= mars_pkg::half_sum(x, mb);
              wd_b <= mars_pkg::half_sum(x, mb); we_b <= 1'b1;
            end
            4'(mars_pkg::MODE_DIFF): begin
              v <= mars_pkg::sat_sub(x, mb);
              wd_b <= x; we_b <= 1'b1;
            end
            4'(mars_pkg::MODE_INTEGRAL): begin
              v <= mars_pkg::sat_add(x, mb);
              wd_b <= mars_pkg::sat_add(x, mb); we_b <= 1'b1;
            end
            default: ;
          endcase
        end
        mars_pkg::ST_SQ_MUL: begin
          // shift-add: high half accumulates, multiplier bits shift out
          prod <= {acc, prod[31:2]};
          bit_cnt <= bit_cnt - 5'd1;
        end
        mars_pkg::ST_SQ_DONE: begin
          a <= sq_val;
          if (mode == 4'(mars_pkg::MODE_SQUARE))
            v <= x[QB-1] ? (~sq_val + 32'd1) : sq_val;
        end
        mars_pkg::ST_CAS1A: begin
          p <= a;
        end
        mars_pkg::ST_CAS2A: begin
          p <= a;
        end
        mars_pkg::ST_CAS1B: begin
          cas <= mars_pkg::sat_sub(mars_pkg::half_sum(p, is_cas2 ? me : mb), p);
          if (is_cas2) begin wd_e <= p; we_e <= 1'b1; end
          else begin wd_b <= p; we_b <= 1'b1; end
        end
        mars_pkg::ST_CAS1C: begin
          if (is_cas2) begin
            a <= mars_pkg::sat_sub(a, mars_pkg::half_sum(cas, mf));
            wd_f <= cas; we_f <= 1'b1;
          end else begin
            a <= mars_pkg::sat_add(a, mars_pkg::half_sum(cas, mc));
            wd_c <= cas; we_c <= 1'b1;
            second <= 1'b1;
          end
        end
        mars_pkg::ST_ROOT_GO, mars_pkg::ST_ROOT_WAIT: ;
        mars_pkg::ST_POST: begin
          if (mode == 4'(mars_pkg::MODE_DIFF_RS)) v <= mars_pkg::sat_add(signed_root, me);
          else if (mode == 4'(mars_pkg::MODE_SQRT)) v <= signed_root;
          else v <= folded;
        end
        mars_pkg::ST_REV: v <= clamped;
        mars_pkg::ST_OUT: if (!out_full || !out_stall) begin
          out_full   <= 1'b1;
          out_sample <= (v == mars_pkg::QOne) ? 24'h7F_FFFF : v[23:0];
          out_chan   <= chan;
          chan       <= chan_next;
        end
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/mars_root.sv
// mars_root: bit-serial square root, floor(sqrt(v * 2^23)) on a 54-bit radicand,
// one result bit per cycle. depends on mars_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mars_root (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire mars_pkg::root_req_t req,
  output mars_pkg::root_rsp_t      rsp
);

  // radicand is < 2^54, so the root fits in 27 bits
  localparam int RootBits = 27;
  localparam int RadBits  = 2 * RootBits;

  logic [RadBits-1:0]  rad;
  logic [RootBits+1:0] rem;
  logic [RootBits-1:0] root;
  logic [4:0]          steps;
  logic                busy;
  logic                done;

  logic [RootBits+1:0] rem_shift;
  logic [RootBits+1:0] trial;
  logic                take;

  always_comb begin
    rem_shift = {rem[RootBits-1:0], rad[RadBits-1 -: 2]};
    trial     = {root, 2'b01};
    take      = rem_shift >= trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy  <= 1'b1;
        steps <= 5'(RootBits - 1);
        rad   <= {req.radicand[30:0], 23'd0};
        rem   <= '0;
        root  <= '0;
      end else if (busy) begin
        rad  <= {rad[RadBits-3:0], 2'b00};
        rem  <= take ? (rem_shift - trial) : rem_shift;
        root <= {root[RootBits-2:0], take};
        if (steps == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          steps <= steps - 5'd1;
        end
      end
    end
  end

  always_comb begin
    rsp.done = done;
    rsp.root = {5'd0, root};
  end

endmodule
`default_nettype wire

// File: tb/tb_top.sv
// tb_top: self-checking bench for multimode_audio_respectrum_filter.
// predicts every filtered sample in the bench and compares each output transfer;
// depends on mars_pkg and the filter rtl.
`timescale 1ns / 1ps
module tb_top;

  localparam int Limit = 3_000_000;

  logic        clk = 0;
  logic        rst = 1;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic        in_valid = 0;
  logic        in_stall;
  logic [23:0] sample_in = '0;
  logic        out_valid;
  logic        out_stall = 0;
  logic [23:0] sample_out;
  logic [7:0]  channel_index;

  multimode_audio_respectrum_filter dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .sample_in(sample_in),
    .out_valid(out_valid), .out_stall(out_stall), .sample_out(sample_out),
    .channel_index(channel_index)
  );

  always #5 clk = ~clk;

  // predictor state
  logic [3:0]     cur_mode;
  logic           cur_rev;
  logic [8:0]     cur_count;
  int unsigned    chan;
  longint         mem_b [256];
  longint         mem_c [256];
  longint         mem_e [256];
  longint         mem_f [256];

  logic [31:0] expected_samples [$];
  int          errors = 0;
  int          cycles = 0;
  int          send_idle = 0;
  int          recv_stall = 0;
  int          hold_off = 0;

  localparam longint QMaxL = 64'sd2147483647;
  localparam longint QMinL = -64'sd2147483648;
  localparam longint OneL  = 64'sd8388608;

  function automatic longint clip(longint v);
    if (v > QMaxL) return QMaxL;
    if (v < QMinL) return QMinL;
    return v;
  endfunction

  function automatic longint halve(longint v);
    return v >>> 1;
  endfunction

  function automatic longint magnitude(longint v);
    return clip(v < 0 ? -v : v);
  endfunction

  function automatic longint sq(longint v);
    longint unsigned m;
    m = v < 0 ? -v : v;
    return clip(longint'((m * m) >> 23));
  endfunction

  function automatic longint root(longint v);
    longint unsigned x, r, b;
    x = longint'(v) << 23;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return longint'(r);
  endfunction

  function automatic longint fold_unit(longint v);
    if (v > OneL) v = clip(OneL - v);
    if (v < -OneL) v = clip(-OneL - v);
    return v;
  endfunction

  function automatic longint averager_pair(longint p, ref longint m1, ref longint m2);
    longint r, t;
    r = halve(p + m1);
    m1 = p;
    r = clip(r - p);
    t = r;
    r = halve(r + m2);
    m2 = t;
    return r;
  endfunction

  // filtered sample and channel for one input transfer
  function automatic logic [31:0] filter_sample(logic [23:0] raw);
    longint x, v, a;
    int unsigned cnt, c;
    cnt = cur_count == 0 ? 1 : (cur_count > 256 ? 256 : cur_count);
    c = chan >= 256 ? 0 : chan;
    x = longint'($signed(raw));
    v = x;
    case (cur_mode)
      mars_pkg::MODE_DIFF_RS: begin
        v = clip(x - mem_e[c]);
        a = sq(v);
        a = clip(a + averager_pair(a, mem_b[c], mem_c[c]));
        a = root(magnitude(a));
        v = clip((v < 0 ? -a : a) + mem_e[c]);
        mem_e[c] = x;
      end
      mars_pkg::MODE_COMPLETE: begin
        a = sq(x);
        a = clip(a + averager_pair(a, mem_b[c], mem_c[c]));
        a = clip(a - averager_pair(a, mem_e[c], mem_f[c]));
        a = root(magnitude(a));
        v = fold_unit(x < 0 ? -a : a);
      end
      mars_pkg::MODE_RS: begin
        a = sq(x);
        a = clip(a + averager_pair(a, mem_b[c], mem_c[c]));
        a = root(magnitude(a));
        v = fold_unit(x < 0 ? -a : a);
      end
      mars_pkg::MODE_SQUARE: begin
        a = sq(x);
        v = x < 0 ? -a : a;
      end
      mars_pkg::MODE_SQRT: begin
        a = root(magnitude(x));
        v = x < 0 ? -a : a;
      end
      mars_pkg::MODE_AVERAGE: begin
        v = halve(x + mem_b[c]);
        mem_b[c] = v;
      end
      mars_pkg::MODE_DIFF: begin
        v = clip(x - mem_b[c]);
        mem_b[c] = x;
      end
      mars_pkg::MODE_INTEGRAL: begin
        v = clip(x + mem_b[c]);
        mem_b[c] = v;
      end
      default: ;
    endcase
    if (cur_rev) v = (cur_mode > 1) ? clip(x + clip(x - v)) : clip(-v);
    if (v < -OneL) v = -OneL;
    if (v > OneL - 1) v = OneL - 1;
    chan = (c + 1 > cnt - 1) ? 0 : c + 1;
    return {v[23:0], c[7:0]};
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("mismatch %s: got %h expected %h", what, got, want);
  endtask

  // output checker
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_samples.size() == 0) begin
        report("unexpected output", {sample_out, channel_index}, '0);
      end else begin
        logic [31:0] want;
        want = expected_samples.pop_front();
        if (sample_out !== want[31:8]) report("sample_out", {8'd0, sample_out},
                                              {8'd0, want[31:8]});
        if (channel_index !== want[7:0]) report("channel_index", {24'd0, channel_index},
                                                {24'd0, want[7:0]});
      end
    end
  end

  // receiver stall, with a long hold-off when requested
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_stall <= 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall);
    end
  end

  always @(posedge clk) begin
    if (cycles > Limit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // leaves cfg_valid high; the caller drops it after its last write
  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      mars_pkg::RegMode:    cur_mode = val[3:0];
      mars_pkg::RegReverse: cur_rev = val[0];
      default:              cur_count = val[8:0];
    endcase
  endtask

  task automatic wait_drained();
    in_valid <= 0;
    while (expected_samples.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic configure(logic [3:0] m, logic r, logic [8:0] n);
    wait_drained();
    write_reg(mars_pkg::RegMode, {28'd0, m});
    write_reg(mars_pkg::RegReverse, {31'd0, r});
    write_reg(mars_pkg::RegCount, {23'd0, n});
    cfg_valid <= 0;
  endtask

  // leaves in_valid high after the transfer; it drops before any gap
  task automatic send_sample(logic [23:0] s);
    if ($urandom_range(99) < send_idle) begin
      in_valid <= 0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle) @(posedge clk);
    end
    in_valid <= 1;
    sample_in <= s;
    expected_samples.push_back(filter_sample(s));
    do @(posedge clk); while (in_stall);
  endtask

  function automatic logic [23:0] rand_sample();
    case ($urandom_range(5))
      0: return 24'h7FFFFF;
      1: return 24'h800000;
      2: return 24'($urandom_range(255) - 128);
      default: return 24'($urandom);
    endcase
  endfunction

  task automatic test_directed();
    logic [23:0] edges [6] = '{24'h7FFFFF, 24'h800000, 24'h000000, 24'hFFFFFF,
                               24'h400000, 24'hC00000};
    for (int m = 0; m < 10; m++) begin
      configure(m == 9 ? 4'd15 : m[3:0], m[0], 9'd2);
      foreach (edges[i]) if (i < 2 || m < 2) send_sample(edges[i]);
    end
    // lowered count with counter beyond it, zero and oversize counts
    configure(mars_pkg::MODE_INTEGRAL, 1'b0, 9'd256);
    repeat (5) send_sample(rand_sample());
    wait_drained();
    write_reg(mars_pkg::RegCount, 32'd2);
    cfg_valid <= 0;
    send_sample(24'h100000);
    configure(mars_pkg::MODE_DIFF, 1'b1, 9'd0);
    send_sample(24'h123456);
    configure(mars_pkg::MODE_DIFF, 1'b0, 9'd511);
    send_sample(24'h654321);
  endtask

  task automatic test_random(int n);
    for (int i = 0; i < n; i++) begin
      if (i % 40 == 0) begin
        int sel;
        sel = $urandom_range(2);
        configure(4'($urandom_range(15)), 1'($urandom_range(1)),
                  sel == 0 ? 9'd1 : (sel == 1 ? 9'd256 : 9'($urandom_range(1, 8))));
      end
      send_sample(rand_sample());
    end
  endtask

  task automatic test_pressure();
    configure(mars_pkg::MODE_AVERAGE, 1'b0, 9'd3);
    hold_off = 600;
    repeat (20) send_sample(rand_sample());
    // sender pauses until everything has drained
    in_valid <= 0;
    while (expected_samples.size() != 0) @(posedge clk);
    repeat (5) send_sample(rand_sample());
  endtask

  initial begin
    cur_mode = mars_pkg::MODE_COPY;
    cur_rev = 0;
    cur_count = 9'd1;
    chan = 0;
    foreach (mem_b[i]) begin
      mem_b[i] = 0;
      mem_c[i] = 0;
      mem_e[i] = 0;
      mem_f[i] = 0;
    end
    repeat (6) @(posedge clk);
    rst <= 0;
    test_directed();
    send_idle = 36;
    recv_stall = 71;
    test_random(270);
    send_idle = 71;
    recv_stall = 36;
    test_random(270);
    send_idle = 0;
    recv_stall = 0;
    test_random(260);
    test_pressure();
    wait_drained();
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
